// ----- hw/rtl/mctu_pkg.sv -----
// Package for the multi-channel timeout unit.
// Holds the action codes, channel numbers and the structs passed between stages.
// No dependencies.
package mctu_pkg;

    // Action carried in tuser
    typedef enum logic [1:0] {
        ACT_SEC_TICK  = 2'd0,
        ACT_FAST_TICK = 2'd1,
        ACT_QUERY     = 2'd2,
        ACT_CLEAR     = 2'd3
    } t_action;

    // Channel numbers with special roles
    localparam logic [2:0] CH_FAST0   = 3'd0;
    localparam logic [2:0] CH_ELAPSED = 3'd4;
    localparam logic [2:0] CH_FAST1   = 3'd6;
    localparam logic [2:0] CH_WATCH   = 3'd7;

    // Seconds counter value after reset
    localparam logic [15:0] SECONDS_AT_RESET = 16'd65500;

    localparam int unsigned DUR_W   = 16;
    localparam int unsigned REPLY_W = 32;

    // One accepted transaction, plus its precomputed fast-tick limit
    typedef struct packed {
        t_action            action;
        logic [2:0]         channel;
        logic [DUR_W-1:0]   duration;
        logic [DUR_W-1:0]   fast_limit;
    } t_item;

    // Result offered to the output register
    typedef struct packed {
        logic               valid;
        logic [REPLY_W-1:0] reply;
    } t_result;

endpackage

// ----- hw/rtl/multi_channel_timeout_unit_top.sv -----
// Eight timeout channels (seconds deadlines, millisecond fast timeouts and a
// stopwatch) fed by seconds and fast tick transactions. One transaction is
// accepted every clock cycle while the result side keeps up; a query or clear
// passes the input register, then the state update that writes its reply into
// the result register, and ticks give no reply. The fast-tick limit is scaled
// by a reciprocal multiply in the input register stage. Reset is synchronous;
// there is no clearing pass.
// Depends on mctu_pkg, mctu_in_stage, mctu_core and mctu_out_stage.
module multi_channel_timeout_unit_top
    import mctu_pkg::*;
#(
    parameter int unsigned MS_PER_FAST_TICK = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [2:0] channel, [18:3] duration, [23:19] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] reply_value
);

    logic    w_in_valid;
    t_item   w_item;
    logic    w_take;
    logic    w_out_free;
    t_result w_result;

    mctu_in_stage #(
        .MS_PER_FAST_TICK (MS_PER_FAST_TICK)
    ) u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_action   (t_action'(s_axis_tuser)),
        .i_channel  (s_axis_tdata[2:0]),
        .i_duration (s_axis_tdata[18:3]),
        .o_valid    (w_in_valid),
        .o_item     (w_item),
        .i_take     (w_take)
    );

    mctu_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_in_valid),
        .i_item     (w_item),
        .i_out_free (w_out_free),
        .o_take     (w_take),
        .o_result   (w_result)
    );

    mctu_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata)
    );

endmodule

// ----- hw/rtl/mctu_in_stage.sv -----
// Input register of the timeout unit, with the duration-to-fast-tick scaling.
// Depends on mctu_pkg.
module mctu_in_stage
    import mctu_pkg::*;
#(
    parameter int unsigned MS_PER_FAST_TICK = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_action    i_action,
    input  logic [2:0] i_channel,
    input  logic [15:0] i_duration,
    output logic       o_valid,
    output t_item      o_item,
    input  logic       i_take
);

    // floor(d / K) as (d * M) >> S, exact for all 16-bit d with M = ceil(2^S / K)
    localparam int unsigned DIV_SHIFT = DUR_W + $clog2(MS_PER_FAST_TICK);
    localparam longint unsigned DIV_MULT =
        ((64'd1 << DIV_SHIFT) + MS_PER_FAST_TICK - 1) / MS_PER_FAST_TICK;
    localparam int unsigned MULT_W = DUR_W + 1;
    localparam int unsigned PROD_W = DUR_W + MULT_W;

    logic [MULT_W-1:0] c_mult;
    logic [PROD_W-1:0] w_prod;
    logic [DUR_W-1:0]  w_limit;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign c_mult  = MULT_W'(DIV_MULT);
    assign w_prod  = PROD_W'(i_duration) * PROD_W'(c_mult);
    assign w_limit = DUR_W'(w_prod >> DIV_SHIFT);

    // Free when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_item.action     = i_action;
        n_item.channel    = i_channel;
        n_item.duration   = i_duration;
        n_item.fast_limit = w_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- hw/rtl/mctu_core.sv -----
// Timeout state and per-transaction update: seconds counter, deadlines,
// wrap flags, window start and the two fast counters. Depends on mctu_pkg.
module mctu_core
    import mctu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    input  logic    i_out_free,
    output logic    o_take,
    output t_result o_result
);

    logic [15:0] r_now, n_now;
    logic [15:0] r_sdl [1:5];
    logic [15:0] n_sdl [1:5];
    logic [1:5]  r_wrap, n_wrap;
    logic [15:0] r_wstart, n_wstart;
    logic [15:0] r_fdl [0:1];
    logic [15:0] n_fdl [0:1];
    logic [15:0] r_flim [0:1];
    logic [15:0] n_flim [0:1];
    logic [31:0] r_fcnt [0:1];
    logic [31:0] n_fcnt [0:1];
    logic [1:0]  r_frun, n_frun;

    logic        w_is_tick;
    logic        w_fast_sel;
    logic [15:0] w_fdl0;
    logic        w_farm;
    logic [15:0] w_flim;
    logic [31:0] w_fcnt;
    logic        w_fstop;
    logic [15:0] w_sdl0, w_sdl1, w_room;
    logic        w_wp0, w_wp1, w_wp2, w_sarm, w_sexp;
    logic [15:0] w_ws1;
    logic [31:0] w_elapsed;
    logic [31:0] w_reply;

    assign w_is_tick = (i_item.action == ACT_SEC_TICK) || (i_item.action == ACT_FAST_TICK);
    // Ticks need no room downstream; queries and clears do
    assign o_take    = i_valid && (w_is_tick || i_out_free);

    // Fast channel view: slot 1 for channel 6, slot 0 otherwise
    always_comb begin
        w_fast_sel = (i_item.channel == CH_FAST1);
        w_fdl0     = r_fdl[w_fast_sel];
        w_fcnt     = r_fcnt[w_fast_sel];
        w_farm     = (w_fdl0 == 16'd0) && (i_item.duration != 16'd0);
        if (w_farm) begin
            w_flim = i_item.fast_limit;
        end else if (w_fdl0 == 16'd0) begin
            w_flim = 16'd0;
        end else begin
            w_flim = r_flim[w_fast_sel];
        end
        w_fstop = (w_fcnt >= 32'(w_flim));
    end

    // Seconds channel view (channels 1 to 5)
    always_comb begin
        w_sdl0 = 16'd0;
        w_wp0  = 1'b0;
        for (int i = 1; i <= 5; i++) begin
            if (i_item.channel == 3'(i)) begin
                w_sdl0 = r_sdl[i];
                w_wp0  = r_wrap[i];
            end
        end
        w_room = 16'hFFFF - r_now;
        w_sarm = (w_sdl0 == 16'd0) && (i_item.duration != 16'd0);
        w_sdl1 = w_sdl0;
        w_wp1  = w_wp0;
        if (w_sarm) begin
            if (i_item.duration > w_room) begin
                w_sdl1 = i_item.duration - w_room;
                w_wp1  = 1'b1;
            end else begin
                w_sdl1 = r_now + i_item.duration;
            end
        end
        w_ws1 = (w_sarm && i_item.channel == CH_ELAPSED) ? r_now : r_wstart;
        w_wp2 = w_wp1 && !(r_now <= w_sdl1);
        w_sexp = (r_now >= w_sdl1) && !w_wp2;
        if ((w_sdl1 >= w_ws1) || w_wp2) begin
            w_elapsed = 32'(r_now) - 32'(w_ws1) + 32'd1;
        end else begin
            w_elapsed = (32'h0000_FFFF - 32'(w_ws1)) + 32'(r_now) + 32'd1;
        end
    end

    // Next state and reply
    always_comb begin
        n_now    = r_now;
        n_sdl    = r_sdl;
        n_wrap   = r_wrap;
        n_wstart = r_wstart;
        n_fdl    = r_fdl;
        n_flim   = r_flim;
        n_fcnt   = r_fcnt;
        n_frun   = r_frun;
        w_reply  = 32'd0;
        case (i_item.action)
            ACT_SEC_TICK: begin
                n_now = r_now + 16'd1;
            end
            ACT_FAST_TICK: begin
                for (int k = 0; k < 2; k++) begin
                    if (r_frun[k]) begin
                        n_fcnt[k] = r_fcnt[k] + 32'd1;
                    end
                end
            end
            ACT_CLEAR: begin
                if (i_item.channel == CH_FAST0 || i_item.channel == CH_WATCH) begin
                    n_frun[0] = 1'b0;
                    n_fcnt[0] = 32'd0;
                    n_fdl[0]  = 16'd0;
                end else if (i_item.channel == CH_FAST1) begin
                    n_frun[1] = 1'b0;
                    n_fcnt[1] = 32'd0;
                    n_fdl[1]  = 16'd0;
                end else begin
                    for (int i = 1; i <= 5; i++) begin
                        if (i_item.channel == 3'(i)) begin
                            n_sdl[i]  = 16'd0;
                            n_wrap[i] = 1'b0;
                        end
                    end
                end
            end
            ACT_QUERY: begin
                if (i_item.channel == CH_FAST0 || i_item.channel == CH_FAST1) begin
                    if (w_farm) begin
                        n_fdl[w_fast_sel]  = i_item.duration;
                        n_flim[w_fast_sel] = i_item.fast_limit;
                        n_frun[w_fast_sel] = 1'b1;
                    end
                    if (w_fstop) begin
                        n_frun[w_fast_sel] = 1'b0;
                        n_fcnt[w_fast_sel] = 32'd0;
                        n_fdl[w_fast_sel]  = 16'd0;
                    end else begin
                        w_reply = (w_fcnt != 32'd0) ? w_fcnt : 32'd1;
                    end
                end else if (i_item.channel == CH_WATCH) begin
                    if (i_item.duration != 16'd0) begin
                        n_frun[0] = 1'b1;
                    end
                    w_reply = (r_fcnt[0] != 32'd0) ? r_fcnt[0] : 32'd1;
                end else begin
                    for (int i = 1; i <= 5; i++) begin
                        if (i_item.channel == 3'(i)) begin
                            n_sdl[i]  = w_sexp ? 16'd0 : w_sdl1;
                            n_wrap[i] = w_wp2;
                        end
                    end
                    n_wstart = w_ws1;
                    if (w_sexp) begin
                        w_reply = 32'd0;
                    end else if (i_item.channel == CH_ELAPSED) begin
                        w_reply = w_elapsed;
                    end else begin
                        w_reply = 32'd1;
                    end
                end
            end
            default: begin
                n_now = r_now;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now    <= SECONDS_AT_RESET;
            r_wrap   <= '0;
            r_wstart <= 16'd0;
            r_frun   <= '0;
            for (int i = 1; i <= 5; i++) begin
                r_sdl[i] <= 16'd0;
            end
            for (int k = 0; k < 2; k++) begin
                r_fdl[k]  <= 16'd0;
                r_flim[k] <= 16'd0;
                r_fcnt[k] <= 32'd0;
            end
        end else if (o_take) begin
            r_now    <= n_now;
            r_sdl    <= n_sdl;
            r_wrap   <= n_wrap;
            r_wstart <= n_wstart;
            r_fdl    <= n_fdl;
            r_flim   <= n_flim;
            r_fcnt   <= n_fcnt;
            r_frun   <= n_frun;
        end
    end

    assign o_result.valid = o_take && !w_is_tick;
    assign o_result.reply = w_reply;

`ifndef SYNTHESIS
    // A seconds tick advances the counter by exactly one
    a_sec_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.action == ACT_SEC_TICK) |=> (r_now == 16'($past(r_now) + 16'd1)))
        else $error("seconds counter did not advance on tick");

    // Ticks never produce a reply
    a_tick_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_is_tick |-> !o_result.valid)
        else $error("tick produced a result");

    // Clearing the fast-0 or stopwatch channel leaves counter 0 stopped and zero
    a_clear_fast0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.action == ACT_CLEAR &&
         (i_item.channel == CH_FAST0 || i_item.channel == CH_WATCH))
        |=> (!r_frun[0] && r_fcnt[0] == 32'd0 && r_fdl[0] == 16'd0))
        else $error("fast counter 0 not cleared");

    // A pending wrap always belongs to an armed deadline
    a_wrap_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wrap[1] |-> r_sdl[1] != 16'd0) and (r_wrap[2] |-> r_sdl[2] != 16'd0) and
        (r_wrap[3] |-> r_sdl[3] != 16'd0) and (r_wrap[4] |-> r_sdl[4] != 16'd0) and
        (r_wrap[5] |-> r_sdl[5] != 16'd0))
        else $error("wrap flag set on unarmed channel");
`endif

endmodule

// ----- hw/rtl/mctu_out_stage.sv -----
// Result register of the timeout unit, driving the master stream side.
// Depends on mctu_pkg.
module mctu_out_stage
    import mctu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_result     i_result,
    output logic        o_free,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_data
);

    logic        r_valid;
    logic [31:0] r_data;

    // Room when empty or when the held result leaves this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_result.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_data <= i_result.reply;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
